[design/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types and constants for the text console writer: transaction
// payloads, operation codes and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int MODE_W = 2;
   localparam int BYTE_W = 8;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int CELL_W = 2 * BYTE_W;

   // Attribute register value after reset.
   localparam logic [BYTE_W-1:0] ATTR_RESET = 8'd7;

   // Operation codes.
   typedef logic [MODE_W-1:0] mode_type;
   localparam mode_type MODE_PUT = 2'd0;
   localparam mode_type MODE_NEWLINE = 2'd1;
   localparam mode_type MODE_CLEAR = 2'd2;
   localparam mode_type MODE_READ = 2'd3;

   // Request transaction payload.
   typedef struct packed {
      mode_type mode;
      logic [BYTE_W-1:0] char_code;
      logic [ROW_FIELD_W-1:0] read_row;
      logic [COL_FIELD_W-1:0] read_col;
   } tcw_req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [BYTE_W-1:0] cell_char;
      logic [BYTE_W-1:0] cell_attr;
      logic [ROW_FIELD_W-1:0] cursor_row;
      logic [COL_FIELD_W-1:0] cursor_col;
   } tcw_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic put_write;
      logic col_adv;
      logic row_down;
      logic scroll_begin;
      logic clear_begin;
      logic sweep_step;
      logic rsp_load;
   } tcw_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      mode_type mode;
      logic col_last;
      logic row_last;
      logic sweep_col_last;
      logic sweep_row_last;
   } tcw_stat_type;

endpackage

[design/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// Text console datapath
// Holds the screen memory, the cursor, the top-of-screen row offset, the
// sweep counters used by clears and scrolls, the attribute register and the
// response register. Acts on controller commands and on CSR attribute writes.
// ----------------------------------------------------------------------------
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic clock,
   input  logic reset,
   input  tcw_req_type req_data,
   input  logic csr_valid,
   input  logic [BYTE_W-1:0] csr_data,
   input  tcw_cmd_type cmd,
   output tcw_stat_type stat,
   output tcw_rsp_type rsp_data
);

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);
   localparam int AW = RW + CW;
   localparam int DEPTH = 2 ** AW;

   // Screen memory: rows are stored in a ring so a scroll only moves the
   // top-of-screen offset and clears one row.
   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rdata_ff;

   tcw_req_type req_ff, req_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] top_ff, top_in;
   logic [RW-1:0] sweep_row_ff, sweep_row_in;
   logic [CW-1:0] sweep_col_ff, sweep_col_in;
   logic [BYTE_W-1:0] attr_ff, attr_in;
   tcw_rsp_type rsp_ff, rsp_in;

   logic [RW:0] cur_sum;
   logic [RW-1:0] cur_phys;
   logic [RW-1:0] rd_row;
   logic [RW:0] rd_sum;
   logic [RW-1:0] rd_phys;
   logic [CW-1:0] rd_col;
   logic rd_in_range;
   logic [RW-1:0] top_next;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic [AW-1:0] rd_addr;

   // Logical cursor row to physical memory row.
   always_comb begin
      cur_sum = {1'b0, row_ff} + {1'b0, top_ff};
      if (cur_sum >= (RW + 1)'(ROWS)) begin
         cur_phys = RW'(cur_sum - (RW + 1)'(ROWS));
      end else begin
         cur_phys = RW'(cur_sum);
      end
   end

   // Read address and range check for read requests.
   always_comb begin
      rd_in_range = (7'(req_ff.read_row) < 7'(ROWS)) && (8'(req_ff.read_col) < 8'(COLS));
      rd_row = RW'(req_ff.read_row);
      rd_col = CW'(req_ff.read_col);
      rd_sum = {1'b0, rd_row} + {1'b0, top_ff};
      if (rd_sum >= (RW + 1)'(ROWS)) begin
         rd_phys = RW'(rd_sum - (RW + 1)'(ROWS));
      end else begin
         rd_phys = RW'(rd_sum);
      end
      rd_addr = {rd_phys, rd_col};
   end

   // Single write port: zero fill during sweeps, character otherwise.
   always_comb begin
      wr_en = cmd.put_write | cmd.sweep_step;
      if (cmd.sweep_step) begin
         wr_addr = {sweep_row_ff, sweep_col_ff};
         wr_data = '0;
      end else begin
         wr_addr = {cur_phys, col_ff};
         wr_data = {attr_ff, req_ff.char_code};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Cursor, ring offset and sweep counters.
   always_comb begin
      top_next = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + 1'b1;
      row_in = row_ff;
      col_in = col_ff;
      top_in = top_ff;
      sweep_row_in = sweep_row_ff;
      sweep_col_in = sweep_col_ff;
      if (cmd.col_adv) begin
         col_in = col_ff + 1'b1;
      end
      if (cmd.row_down) begin
         row_in = row_ff + 1'b1;
         col_in = '0;
      end
      if (cmd.scroll_begin) begin
         // The old top row becomes the new bottom row and is cleared.
         col_in = '0;
         top_in = top_next;
         sweep_row_in = top_ff;
         sweep_col_in = '0;
      end
      if (cmd.clear_begin) begin
         row_in = '0;
         col_in = '0;
         top_in = '0;
         sweep_row_in = '0;
         sweep_col_in = '0;
      end
      if (cmd.sweep_step) begin
         if (sweep_col_ff == CW'(COLS - 1)) begin
            sweep_col_in = '0;
            sweep_row_in = sweep_row_ff + 1'b1;
         end else begin
            sweep_col_in = sweep_col_ff + 1'b1;
         end
      end
   end

   // Attribute register written from the CSR channel.
   always_comb begin
      attr_in = csr_valid ? csr_data : attr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         top_ff <= '0;
         sweep_row_ff <= '0;
         sweep_col_ff <= '0;
         attr_ff <= ATTR_RESET;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         top_ff <= top_in;
         sweep_row_ff <= sweep_row_in;
         sweep_col_ff <= sweep_col_in;
         attr_ff <= attr_in;
      end
   end

   // Request capture and response register.
   always_comb begin
      req_in = cmd.load_req ? req_data : req_ff;
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         if (req_ff.mode == MODE_READ && rd_in_range) begin
            rsp_in.cell_char = rdata_ff[BYTE_W-1:0];
            rsp_in.cell_attr = rdata_ff[CELL_W-1:BYTE_W];
         end else begin
            rsp_in.cell_char = '0;
            rsp_in.cell_attr = '0;
         end
         rsp_in.cursor_row = ROW_FIELD_W'(row_ff);
         rsp_in.cursor_col = COL_FIELD_W'(col_ff);
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // Status for the controller.
   always_comb begin
      stat.mode = req_ff.mode;
      stat.col_last = (col_ff == CW'(COLS - 1));
      stat.row_last = (row_ff == RW'(ROWS - 1));
      stat.sweep_col_last = (sweep_col_ff == CW'(COLS - 1));
      stat.sweep_row_last = (sweep_row_ff == RW'(ROWS - 1));
   end

   assign rsp_data = rsp_ff;

endmodule

[design/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// Text console controller
// State machine that sequences each transaction: request capture, decode,
// screen and row sweeps, and the one-cycle response strobe.
// ----------------------------------------------------------------------------
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  tcw_stat_type stat,
   output tcw_cmd_type cmd,
   output logic busy,
   output logic rsp_valid
);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_DECODE = 6'b000100,
      ST_CLEAR  = 6'b001000,
      ST_SCROLL = 6'b010000,
      ST_FINISH = 6'b100000
   } tcw_state_type;

   tcw_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_INIT: begin
            // Clearing pass over the whole screen after reset.
            cmd.sweep_step = 1'b1;
            if (stat.sweep_col_last && stat.sweep_row_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.mode)
               MODE_PUT, MODE_NEWLINE: begin
                  cmd.put_write = (stat.mode == MODE_PUT);
                  if (stat.mode == MODE_PUT && !stat.col_last) begin
                     cmd.col_adv = 1'b1;
                     state_in = ST_FINISH;
                  end else if (!stat.row_last) begin
                     cmd.row_down = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     cmd.scroll_begin = 1'b1;
                     state_in = ST_SCROLL;
                  end
               end
               MODE_CLEAR: begin
                  cmd.clear_begin = 1'b1;
                  state_in = ST_CLEAR;
               end
               default: begin
                  // Read: the memory read is issued this cycle.
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_col_last && stat.sweep_row_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_SCROLL: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_col_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/text_console_writer.sv]
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode screen store of ROWS by COLS character/attribute cells with a
// cursor; supports put character, newline, clear screen and cell read.
// ----------------------------------------------------------------------------
// One transaction is taken while busy is low; its response appears on the
// rsp_ ports for exactly one cycle with rsp_valid high, and the receiver
// cannot stall it. Put character, newline and read pass through the decode
// and finish states to a registered response. A newline on the bottom row
// (also one caused by a put at the last column) scrolls: rows live in a
// ring in memory, so a scroll clears one row. Clear screen writes every
// cell. After reset a clearing pass over every cell runs with busy high.
// Clears, scrolls and the clearing pass all use the single write port of the
// screen memory, which zeroes one cell per cycle. The attribute register may
// be written at any time through the csr_ channel, which is always ready.
// ----------------------------------------------------------------------------
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  tcw_req_type req_data,
   output logic rsp_valid,
   output tcw_rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [BYTE_W-1:0] csr_data
);

   tcw_cmd_type cmd;
   tcw_stat_type stat;

   // Controller.
   tcw_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .stat(stat),
      .cmd(cmd),
      .busy(busy),
      .rsp_valid(rsp_valid)
   );

   // Datapath.
   tcw_datapath #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .csr_valid(csr_valid),
      .csr_data(csr_data),
      .cmd(cmd),
      .stat(stat),
      .rsp_data(rsp_data)
   );

   // The attribute register accepts a write in every cycle.
   assign csr_ready = 1'b1;

endmodule

[design/tcw_checker.sv]
// ----------------------------------------------------------------------------
// Text console checker
// Port-level assertions on the text console writer, attached by bind.
// ----------------------------------------------------------------------------
module tcw_checker
   import tcw_pkg::*;
#(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input tcw_rsp_type rsp_data
);

   // An accepted transaction makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a transaction");

   // A response strobe lasts a single cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // A response only ends a period of busy work.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a transaction in progress");

   // The reported cursor lies on the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (8'(rsp_data.cursor_col) < 8'(COLS)) &&
                    (7'(rsp_data.cursor_row) < 7'(ROWS)))
      else $error("cursor reported outside the screen");

endmodule

bind text_console_writer tcw_checker #(
   .ROWS(ROWS),
   .COLS(COLS)
) u_tcw_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_data(rsp_data)
);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put-character, newline, clear-screen and cell-read transactions into
// the text console writer with random gaps, and checks every response against
// a shadow screen kept in the testbench. The run covers the reset attribute,
// several attribute settings including both extremes, line wraps at the last
// column, scrolls off the bottom row and reads outside the screen.
// ----------------------------------------------------------------------------
module tb_top;
   import tcw_pkg::*;

   localparam int ROWS = 25;
   localparam int COLS = 80;
   localparam int CELLS = ROWS * COLS;
   localparam int CLK_HALF = 6;
   localparam int PHASE_ITEMS = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tcw_req_type req_data = '0;
   logic rsp_valid;
   tcw_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [BYTE_W-1:0] csr_data = '0;

   // Transactions waiting for the driver, and responses still owed by the block.
   tcw_req_type pending_req_q[$];
   tcw_rsp_type expected_rsp_q[$];

   // Shadow copy of the screen, cursor and attribute register.
   logic [CELL_W-1:0] screen_img [CELLS];
   int cur_row;
   int cur_col;
   logic [BYTE_W-1:0] attr_shadow = ATTR_RESET;

   int mismatch_count = 0;
   int gap_left = 0;
   int calm_left = 0;
   logic req_taken = 1'b0;

   text_console_writer #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // Shadow screen operations.
   task automatic console_clear();
      foreach (screen_img[i]) screen_img[i] = '0;
      cur_row = 0;
      cur_col = 0;
   endtask

   task automatic console_newline();
      if (cur_row + 1 < ROWS) begin
         cur_row++;
      end else begin
         for (int i = 0; i < CELLS - COLS; i++) screen_img[i] = screen_img[i + COLS];
         for (int i = CELLS - COLS; i < CELLS; i++) screen_img[i] = '0;
         cur_row = ROWS - 1;
      end
      cur_col = 0;
   endtask

   // Applies one transaction to the shadow screen and returns the response.
   task automatic console_apply(input tcw_req_type r, output tcw_rsp_type o);
      o = '0;
      case (r.mode)
         MODE_PUT: begin
            screen_img[cur_row * COLS + cur_col] = {attr_shadow, r.char_code};
            if (cur_col + 1 < COLS) cur_col++;
            else console_newline();
         end
         MODE_NEWLINE: begin
            console_newline();
         end
         MODE_CLEAR: begin
            console_clear();
         end
         MODE_READ: begin
            if (r.read_row < ROWS && r.read_col < COLS)
               {o.cell_attr, o.cell_char} = screen_img[r.read_row * COLS + r.read_col];
         end
      endcase
      o.cursor_row = cur_row[ROW_FIELD_W-1:0];
      o.cursor_col = cur_col[COL_FIELD_W-1:0];
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [BYTE_W-1:0] got,
                              input logic [BYTE_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h",
                                                  name, got, want));
   endtask

   // Gap before the next transaction: mostly none or short, a few long, and
   // now and then a stretch of back-to-back transactions.
   function automatic int next_gap();
      int pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end else if (pick < 40) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(10, 60);
      end
   endfunction

   // Driver: presents the next pending transaction once the previous one is taken.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         // Hold the transaction until the block takes it.
      end else if (gap_left != 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_req_q.size() != 0) begin
         start <= 1'b1;
         req_data <= pending_req_q.pop_front();
         gap_left <= next_gap();
      end else begin
         start <= 1'b0;
      end
   end

   // Accepted transactions and attribute writes update the shadow state.
   always @(posedge clock) begin
      tcw_rsp_type predicted;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (csr_valid && csr_ready) attr_shadow = csr_data;
         if (start && !busy) begin
            console_apply(req_data, predicted);
            expected_rsp_q.push_back(predicted);
         end
      end
   end

   // Monitor: every response is compared with the oldest expected one.
   always @(posedge clock) begin
      tcw_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("response with no transaction outstanding");
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("cell_char", rsp_data.cell_char, want.cell_char);
            check_field("cell_attr", rsp_data.cell_attr, want.cell_attr);
            check_field("cursor_row", BYTE_W'(rsp_data.cursor_row), BYTE_W'(want.cursor_row));
            check_field("cursor_col", BYTE_W'(rsp_data.cursor_col), BYTE_W'(want.cursor_col));
         end
      end
   end

   // Stimulus helpers.
   function automatic tcw_req_type random_req(input mode_type m);
      tcw_req_type r;
      r = tcw_req_type'({$urandom, $urandom});
      r.mode = m;
      return r;
   endfunction

   task automatic push_req(input mode_type m, input logic [BYTE_W-1:0] ch,
                           input int row, input int col);
      tcw_req_type r;
      r = random_req(m);
      if (m == MODE_PUT) r.char_code = ch;
      if (m == MODE_READ) begin
         r.read_row = row[ROW_FIELD_W-1:0];
         r.read_col = col[COL_FIELD_W-1:0];
      end
      pending_req_q.push_back(r);
   endtask

   // Mostly lines of text, newlines and reads of the screen; a little noise.
   task automatic push_random_phase(input int n_items);
      int count;
      int pick;
      int len;
      count = 0;
      while (count < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(COLS - 2, COLS + 2)
                                              : $urandom_range(1, 30);
            repeat (len) push_req(MODE_PUT, BYTE_W'($urandom_range(0, 255)), 0, 0);
            count += len;
            if ($urandom_range(0, 9) < 7) begin
               push_req(MODE_NEWLINE, 0, 0, 0);
               count++;
            end
         end else if (pick < 82) begin
            len = $urandom_range(1, 4);
            repeat (len) begin
               if ($urandom_range(0, 4) == 0)
                  push_req(MODE_READ, 0, $urandom_range(0, 31), $urandom_range(0, 127));
               else
                  push_req(MODE_READ, 0, $urandom_range(0, ROWS - 1),
                           $urandom_range(0, COLS - 1));
            end
            count += len;
         end else if (pick < 92) begin
            len = $urandom_range(1, 30);
            repeat (len) push_req(MODE_NEWLINE, 0, 0, 0);
            count += len;
         end else if (pick < 95) begin
            push_req(MODE_CLEAR, 0, 0, 0);
            count++;
         end else begin
            pending_req_q.push_back(random_req(mode_type'($urandom_range(0, 3))));
            count++;
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_req_q.size() != 0 || start || expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_attr(input logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Main sequence.
   initial begin
      logic [BYTE_W-1:0] attr_list [4];
      attr_list = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom)};
      console_clear();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the reset attribute.
      push_req(MODE_READ, 0, 0, 0);
      push_req(MODE_READ, 0, 31, 127);
      push_req(MODE_PUT, 8'h00, 0, 0);
      push_req(MODE_PUT, 8'hFF, 0, 0);
      push_req(MODE_PUT, 8'h5A, 0, 0);
      push_req(MODE_READ, 0, 0, 0);
      push_req(MODE_READ, 0, 0, 1);
      push_req(MODE_READ, 0, 0, 2);
      push_req(MODE_READ, 0, ROWS - 1, COLS - 1);
      push_req(MODE_READ, 0, ROWS, 0);
      push_req(MODE_READ, 0, 0, COLS);
      push_req(MODE_NEWLINE, 0, 0, 0);
      push_req(MODE_PUT, 8'hA5, 0, 0);
      push_req(MODE_READ, 0, 1, 0);
      push_req(MODE_CLEAR, 0, 0, 0);
      push_req(MODE_READ, 0, 0, 0);
      push_req(MODE_READ, 0, 1, 0);
      wait_drained();

      // Random phases, each under its own attribute setting.
      foreach (attr_list[i]) begin
         write_attr(attr_list[i]);
         push_req(MODE_PUT, 8'h80, 0, 0);
         push_random_phase(PHASE_ITEMS);
         wait_drained();
      end

      repeat (CELLS + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #(64'd200_000_000);
      $display("tb_top failed");
      $finish;
   end

endmodule

[text_console_writer.f]
design/tcw_pkg.sv
design/tcw_datapath.sv
design/tcw_ctrl.sv
design/text_console_writer.sv
design/tcw_checker.sv
test/tb_top.sv
